>>> design/mrrs_pkg.sv
// mrrs_pkg: shared types and constants for the modbus rtu register slave
// no dependencies
`timescale 1ns / 1ps
package mrrs_pkg;
  localparam int REG_COUNT = 64;
  localparam int MAX_READ = 16;
  localparam int REG_AW = $clog2(REG_COUNT);
  localparam logic [7:0] FN_READ = 8'd3;
  localparam logic [7:0] FN_WRITE = 8'd6;
  localparam logic [7:0] MIN_FRAME = 8'd8;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [0:0] CFG_DEV_ADDR = 1'b0;
  localparam logic [0:0] CFG_REG_USE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RXCRC, ST_EVAL, ST_RDREQ, ST_RDWAIT, ST_SEND, ST_TXCRC, ST_DONE
  } state_t;

  // crc unit control
  typedef struct packed {
    logic       load;   // load value
    logic [15:0] init;
    logic       feed;   // xor byte in
    logic [7:0] byte_in;
    logic       shift;  // one bit step
  } crc_ctl_t;
endpackage

>>> design/mrrs_crc.sv
// mrrs_crc: bit-serial crc-16 unit, one polynomial step per cycle while shift is asserted
// depends on mrrs_pkg
`timescale 1ns / 1ps
module mrrs_crc (
  input  logic             clk,
  input  mrrs_pkg::crc_ctl_t ctl,
  output logic [15:0]      crc
);
  logic [15:0] crc_r, crc_nxt;
  always_comb begin
    crc_nxt = crc_r;
    if (ctl.load) crc_nxt = ctl.init;
    else if (ctl.feed) crc_nxt = crc_r ^ {8'h00, ctl.byte_in};
    else if (ctl.shift) begin
      crc_nxt = crc_r[0] ? ((crc_r >> 1) ^ mrrs_pkg::CRC_POLY) : (crc_r >> 1);
    end
  end
  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
  end
  assign crc = crc_r;
endmodule

>>> design/mrrs_regfile.sv
// mrrs_regfile: holding register memory, one write and one registered read port
// depends on mrrs_pkg; entry i reads i+1 until written (valid bits)
`timescale 1ns / 1ps
module mrrs_regfile (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    we,
  input  logic [mrrs_pkg::REG_AW-1:0] waddr,
  input  logic [15:0]             wdata,
  input  logic [mrrs_pkg::REG_AW-1:0] raddr,
  output logic [15:0]             rdata
);
  logic [15:0] mem [mrrs_pkg::REG_COUNT];
  logic [mrrs_pkg::REG_COUNT-1:0] vld_r;
  logic [15:0] rd_r;
  logic rv_r;
  logic [mrrs_pkg::REG_AW-1:0] ra_r;
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_r <= mem[raddr];
    ra_r <= raddr;
    rv_r <= vld_r[raddr];
  end
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (we) vld_r[waddr] <= 1'b1;
  end
  assign rdata = rv_r ? rd_r : 16'({{(16-mrrs_pkg::REG_AW){1'b0}}, ra_r} + 16'd1);
endmodule

>>> design/mrrs_ctrl.sv
// mrrs_ctrl: frame sequencer driving the shared crc unit and register file
// depends on mrrs_pkg, mrrs_crc, mrrs_regfile
`timescale 1ns / 1ps
module mrrs_ctrl (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] dev_addr,
  input  logic [6:0] reg_use,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_byte,
  output logic       out_last
);
  localparam int AW = mrrs_pkg::REG_AW;
  mrrs_pkg::state_t st_r, st_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] hdr_r [6];
  logic [7:0] tr0_r, tr1_r, tr0_nxt, tr1_nxt;
  logic [2:0] bit_r, bit_nxt;
  logic [5:0] idx_r, idx_nxt;     // response byte index
  logic [5:0] nby_r, nby_nxt;     // response bytes before crc
  logic [15:0] rcrc_r, rcrc_nxt;  // crc computed over the received frame
  logic [7:0] ob_r, ob_nxt;
  logic ol_r, ol_nxt, ov_r, ov_nxt;
  logic lst_r, lst_nxt;           // frame end flag of the request in progress
  logic [15:0] rd_hold_r, rd_hold_nxt;
  logic take_in;
  mrrs_pkg::crc_ctl_t ctl;
  logic [15:0] crc;
  logic we;
  logic [AW-1:0] raddr;
  logic [15:0] rdata;
  logic [15:0] a16, v16;
  logic [7:0] lim;
  logic [16:0] ridx;
  logic ok;

  mrrs_crc u_crc (.clk(clk), .ctl(ctl), .crc(crc));
  mrrs_regfile u_rf (.clk(clk), .rst_n(rst_n), .we(we), .waddr(a16[AW-1:0]),
    .wdata(v16), .raddr(raddr), .rdata(rdata));

  assign a16 = {hdr_r[2], hdr_r[3]};
  assign v16 = {hdr_r[4], hdr_r[5]};
  assign lim = (reg_use > 7'(mrrs_pkg::REG_COUNT)) ? 8'(mrrs_pkg::REG_COUNT) : {1'b0, reg_use};
  // register for read word k = (idx-3)/2
  assign ridx = {1'b0, a16} + 17'({idx_r - 6'd3} >> 1);
  assign raddr = ridx[AW-1:0];
  assign ok = (len_r >= mrrs_pkg::MIN_FRAME) && (tr0_r == rcrc_r[15:8])
    && (tr1_r == rcrc_r[7:0]) && (hdr_r[0] == dev_addr);
  assign take_in = in_tvalid && in_tready;
  assign in_tready = (st_r == mrrs_pkg::ST_IDLE);
  assign out_tvalid = ov_r;
  assign out_byte = ob_r;
  assign out_last = ol_r;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      mrrs_pkg::ST_IDLE: if (take_in) st_nxt = (len_r >= 8'd2) ? mrrs_pkg::ST_RXCRC
        : (in_last ? mrrs_pkg::ST_EVAL : mrrs_pkg::ST_IDLE);
      mrrs_pkg::ST_RXCRC: if (bit_r == 3'd7) st_nxt = mrrs_pkg::ST_DONE;
      mrrs_pkg::ST_DONE: st_nxt = lst_r ? mrrs_pkg::ST_EVAL : mrrs_pkg::ST_IDLE;
      mrrs_pkg::ST_EVAL: begin
        st_nxt = mrrs_pkg::ST_IDLE;
        if (ok && hdr_r[1] == mrrs_pkg::FN_READ && v16 >= 16'd1
            && v16 <= 16'(mrrs_pkg::MAX_READ)) st_nxt = mrrs_pkg::ST_RDREQ;
      end
      mrrs_pkg::ST_RDREQ: st_nxt = mrrs_pkg::ST_RDWAIT;
      mrrs_pkg::ST_RDWAIT: if (!ov_r || out_tready) st_nxt = mrrs_pkg::ST_SEND;
      mrrs_pkg::ST_SEND: if (bit_r == 3'd7) st_nxt = (idx_r == nby_r)
        ? mrrs_pkg::ST_TXCRC : mrrs_pkg::ST_RDREQ;
      mrrs_pkg::ST_TXCRC: if (!ov_r || out_tready)
        st_nxt = (idx_r == nby_r + 6'd1) ? mrrs_pkg::ST_IDLE : mrrs_pkg::ST_TXCRC;
      default: st_nxt = mrrs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    we = 1'b0;
    len_nxt = len_r; tr0_nxt = tr0_r; tr1_nxt = tr1_r;
    bit_nxt = bit_r; idx_nxt = idx_r; nby_nxt = nby_r; rcrc_nxt = rcrc_r;
    ob_nxt = ob_r; ol_nxt = ol_r; ov_nxt = ov_r && !out_tready;
    lst_nxt = lst_r;
    rd_hold_nxt = rd_hold_r;
    ctl.init = mrrs_pkg::CRC_INIT;
    ctl.byte_in = tr0_r;
    case (st_r)
      mrrs_pkg::ST_IDLE: if (take_in) begin
        if (len_r >= 8'd2) ctl.feed = 1'b1;
        tr0_nxt = tr1_r; tr1_nxt = in_byte;
        if (len_r != 8'hFF) len_nxt = len_r + 8'd1;
        lst_nxt = in_last; bit_nxt = 3'd0;
      end
      mrrs_pkg::ST_RXCRC: begin
        ctl.shift = 1'b1; bit_nxt = bit_r + 3'd1;
      end
      mrrs_pkg::ST_DONE: rcrc_nxt = crc;
      mrrs_pkg::ST_EVAL: begin
        if (ok && hdr_r[1] == mrrs_pkg::FN_WRITE && a16 < {8'd0, lim}) we = 1'b1;
        len_nxt = 8'd0; tr0_nxt = 8'd0; tr1_nxt = 8'd0;
        ctl.load = 1'b1; rcrc_nxt = mrrs_pkg::CRC_INIT;
        idx_nxt = 6'd0; nby_nxt = 6'(v16[4:0]) * 6'd2 + 6'd3;
      end
      mrrs_pkg::ST_RDWAIT: begin
        rd_hold_nxt = (ridx < {9'd0, lim}) ? rdata : 16'd0;
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1; ol_nxt = 1'b0; bit_nxt = 3'd0;
          case (idx_r)
            6'd0: ob_nxt = hdr_r[0];
            6'd1: ob_nxt = hdr_r[1];
            6'd2: ob_nxt = {v16[6:0], 1'b0};
            default: ob_nxt = idx_r[0] ? ((ridx < {9'd0, lim}) ? rdata[15:8] : 8'd0)
              : rd_hold_r[7:0];
          endcase
          if (idx_r >= 6'd3 && !idx_r[0]) ob_nxt = rd_hold_r[7:0];
          ctl.feed = 1'b1; ctl.byte_in = ob_nxt;
          idx_nxt = idx_r + 6'd1;
        end
        if (idx_r >= 6'd3 && !idx_r[0]) rd_hold_nxt = rd_hold_r;
      end
      mrrs_pkg::ST_SEND: begin
        ctl.shift = 1'b1; bit_nxt = bit_r + 3'd1;
      end
      mrrs_pkg::ST_TXCRC: if (!ov_r || out_tready) begin
        ov_nxt = 1'b1;
        ob_nxt = (idx_r == nby_r) ? crc[15:8] : crc[7:0];
        ol_nxt = (idx_r != nby_r);
        idx_nxt = idx_r + 6'd1;
        // rearm the crc unit for the next request frame
        if (idx_r != nby_r) ctl.load = 1'b1;
      end
      default: ;
    endcase
    if (!rst_n) ctl.load = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= mrrs_pkg::ST_IDLE; len_r <= '0; tr0_r <= '0; tr1_r <= '0;
      ov_r <= 1'b0; ol_r <= 1'b0; bit_r <= '0; idx_r <= '0; nby_r <= '0;
      rcrc_r <= mrrs_pkg::CRC_INIT; lst_r <= 1'b0;
    end else begin
      st_r <= st_nxt; len_r <= len_nxt; tr0_r <= tr0_nxt; tr1_r <= tr1_nxt;
      ov_r <= ov_nxt; ol_r <= ol_nxt; bit_r <= bit_nxt; idx_r <= idx_nxt;
      nby_r <= nby_nxt; rcrc_r <= rcrc_nxt; lst_r <= lst_nxt;
    end
  end
  // crc value itself is loaded while reset is held
  always_ff @(posedge clk) begin
    ob_r <= ob_nxt; rd_hold_r <= rd_hold_nxt;
    if (take_in && len_r < 8'd6) hdr_r[3'(len_r)] <= in_byte;
  end
endmodule

>>> design/modbus_rtu_register_slave_top.sv
// modbus_rtu_register_slave_top: modbus rtu slave over 64 holding registers
// depends on mrrs_pkg, mrrs_ctrl
//
// channel | direction | tdata (low bit up)   | tlast
// in_     | request   | rx_byte[7:0]         | frame_end
// out_    | response  | tx_byte[7:0]         | tx_last
// cfg_    | write     | 0 device_address, 1 registers_in_use
//
// the first two request bytes of a frame are only captured; every later byte is
// captured, then runs the bit-serial steps of the shared crc unit, one per bit,
// then the crc latch; the frame end then goes on to evaluation
// each response byte before the crc passes read request, read wait and one crc
// step per bit; each response crc byte is sent without crc steps
// reset clears the frame state; registers reload i+1 through valid bits
// a stalled response holds the sequencer before the next byte
`timescale 1ns / 1ps
module modbus_rtu_register_slave_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // rx_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // tx_byte
  output logic       out_tlast
);
  logic [7:0] dev_addr_r;
  logic [6:0] reg_use_r;
  // crc unit starts at its load value: first frame loads crc on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= 8'd1;
      reg_use_r <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        mrrs_pkg::CFG_DEV_ADDR: dev_addr_r <= cfg_data;
        mrrs_pkg::CFG_REG_USE: reg_use_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end
  mrrs_ctrl u_ctrl (.clk(clk), .rst_n(rst_n), .dev_addr(dev_addr_r), .reg_use(reg_use_r),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_byte(in_tdata), .in_last(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_byte(out_tdata),
    .out_last(out_tlast));
endmodule

>>> design/mrrs_checker.sv
// mrrs_checker: port-level checks for the register slave
// depends on modbus_rtu_register_slave_top ports only
`timescale 1ns / 1ps
module mrrs_checker (
  input logic clk, input logic rst_n,
  input logic in_tvalid, input logic in_tready, input logic in_tlast,
  input logic out_tvalid, input logic out_tready, input logic out_tlast,
  input logic [7:0] out_tdata
);
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready) else $error("ready after frame end");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("stall");
  a_noin: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready) else $error("request during reply");
endmodule

bind modbus_rtu_register_slave_top mrrs_checker u_chk (.clk(clk), .rst_n(rst_n),
  .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tlast(in_tlast),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tlast(out_tlast),
  .out_tdata(out_tdata));

>>> bench/modbus_slave_checker.sv
// modbus_slave_checker: predicts response bytes of the modbus rtu register slave
// depends on mrrs_pkg; watches the request, response and cfg ports of the top
`timescale 1ns / 1ps
module modbus_slave_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,
  input  logic       out_tlast,
  output int         fail_count,
  output int         pending_bytes
);
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_last;
  } resp_byte_t;

  logic [15:0] regfile [mrrs_pkg::REG_COUNT];
  logic [15:0] rx_crc;
  logic [7:0]  rx_len;
  logic [7:0]  hdr [6];
  logic [7:0]  tail [2];
  logic [7:0]  dev_addr;
  logic [6:0]  regs_in_use;
  resp_byte_t  expected_resp [$];

  function automatic logic [15:0] crc16_byte(logic [15:0] c, logic [7:0] b);
    c = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++)
      c = c[0] ? ((c >> 1) ^ mrrs_pkg::CRC_POLY) : (c >> 1);
    return c;
  endfunction

  task automatic push_resp(logic [7:0] b, logic lst, inout logic [15:0] c);
    resp_byte_t r;
    r.tx_byte = b;
    r.tx_last = lst;
    expected_resp.push_back(r);
    c = crc16_byte(c, b);
  endtask

  // frame end: validate and act on the request
  task automatic finish_frame();
    logic [15:0] addr, val, c, rv;
    int lim;
    addr = {hdr[2], hdr[3]};
    val  = {hdr[4], hdr[5]};
    lim  = (regs_in_use > mrrs_pkg::REG_COUNT) ? mrrs_pkg::REG_COUNT : regs_in_use;
    if (rx_len >= mrrs_pkg::MIN_FRAME && tail[0] == rx_crc[15:8] && tail[1] == rx_crc[7:0]
        && hdr[0] == dev_addr) begin
      if (hdr[1] == mrrs_pkg::FN_READ && val >= 1 && val <= mrrs_pkg::MAX_READ) begin
        c = mrrs_pkg::CRC_INIT;
        push_resp(hdr[0], 1'b0, c);
        push_resp(hdr[1], 1'b0, c);
        push_resp(8'(val * 2), 1'b0, c);
        for (int i = 0; i < val; i++) begin
          rv = (int'(addr) + i < lim) ? regfile[int'(addr) + i] : 16'h0;
          push_resp(rv[15:8], 1'b0, c);
          push_resp(rv[7:0], 1'b0, c);
        end
        rv = c;
        push_resp(rv[15:8], 1'b0, c);
        push_resp(rv[7:0], 1'b1, c);
      end else if (hdr[1] == mrrs_pkg::FN_WRITE && int'(addr) < lim) begin
        regfile[addr[mrrs_pkg::REG_AW-1:0]] = val;
      end
    end
    rx_crc = mrrs_pkg::CRC_INIT;
    rx_len = '0;
    tail[0] = '0;
    tail[1] = '0;
  endtask

  always @(posedge clk) begin
    resp_byte_t e;
    if (!rst_n) begin
      for (int i = 0; i < mrrs_pkg::REG_COUNT; i++) regfile[i] <= 16'(i + 1);
      for (int i = 0; i < 6; i++) hdr[i] <= '0;
      rx_crc <= mrrs_pkg::CRC_INIT;
      rx_len <= '0;
      tail[0] <= '0;
      tail[1] <= '0;
      dev_addr <= 8'd1;
      regs_in_use <= 7'd64;
      expected_resp.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == mrrs_pkg::CFG_DEV_ADDR) dev_addr = cfg_data;
        else regs_in_use = cfg_data[6:0];
      end
      if (out_tvalid && out_tready) begin
        if (expected_resp.size() == 0) begin
          $display("%0t: unexpected response byte %02h last %0b", $time, out_tdata,
                   out_tlast);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_resp.pop_front();
          if (e.tx_byte !== out_tdata || e.tx_last !== out_tlast) begin
            $display("%0t: response mismatch expected %02h/%0b got %02h/%0b", $time,
                     e.tx_byte, e.tx_last, out_tdata, out_tlast);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (rx_len >= 2) rx_crc = crc16_byte(rx_crc, tail[0]);
        tail[0] = tail[1];
        tail[1] = in_tdata;
        if (rx_len < 6) hdr[rx_len] = in_tdata;
        if (rx_len < 255) rx_len = rx_len + 1;
        if (in_tlast) finish_frame();
      end
    end
    pending_bytes = expected_resp.size();
  end
endmodule

>>> bench/tb_modbus_rtu_register_slave_top.sv
// tb_modbus_rtu_register_slave_top: stimulus and verdict for the register slave
// depends on mrrs_pkg, modbus_rtu_register_slave_top, modbus_slave_checker
`timescale 1ns / 1ps
module tb_modbus_rtu_register_slave_top;
  localparam int STALL_LIMIT = 20000;  // cycles with no handshake at all

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [0:0] cfg_index = mrrs_pkg::CFG_DEV_ADDR;
  logic [7:0] cfg_data = '0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = '0;   // rx_byte
  logic       in_tlast = 1'b0; // frame_end
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;       // tx_byte
  logic       out_tlast;       // tx_last
  int         fail_count;
  int         pending_bytes;

  // stimulus view of the slave address, for building matching frames
  logic [7:0] cur_addr = 8'd1;
  bit         quiet_mode = 1'b0;   // final stretch: no idling on either side
  int         hold_off = 0;        // long receiver hold-off request, in cycles
  int         idle_cycles = 0;

  always #2 clk = ~clk;

  modbus_rtu_register_slave_top dut (.*);

  modbus_slave_checker chk (.*);

  // watchdog on handshake activity
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        n = hold_off;
        hold_off = 0;
        out_tready <= 1'b0;
        repeat (n) @(negedge clk);
        out_tready <= 1'b1;
      end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic logic [15:0] frame_crc(input logic [7:0] b [$]);
    logic [15:0] c;
    c = mrrs_pkg::CRC_INIT;
    foreach (b[i]) begin
      c = c ^ {8'h00, b[i]};
      for (int k = 0; k < 8; k++)
        c = c[0] ? ((c >> 1) ^ mrrs_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // one request byte, with optional sender gap before it
  task automatic send_byte(logic [7:0] b, logic lst);
    if (!quiet_mode && $urandom_range(0, 4) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = b;
    in_tlast = lst;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // body bytes plus crc trailer, high byte first; corrupt flips the crc
  task automatic send_frame(logic [7:0] body [$], bit corrupt);
    logic [15:0] c;
    c = frame_crc(body);
    if (corrupt) c = c ^ 16'(1 << $urandom_range(0, 15));
    foreach (body[i]) send_byte(body[i], 1'b0);
    send_byte(c[15:8], 1'b0);
    send_byte(c[7:0], 1'b1);
  endtask

  task automatic send_request(logic [7:0] addr, logic [7:0] fn, logic [15:0] idx,
                              logic [15:0] val);
    logic [7:0] body [$];
    body = '{addr, fn, idx[15:8], idx[7:0], val[15:8], val[7:0]};
    send_frame(body, 1'b0);
  endtask

  task automatic drain();
    while (pending_bytes != 0) @(negedge clk);
    repeat (40) @(negedge clk);  // evaluation of a silent frame may still be running
  endtask

  task automatic write_cfg(logic [0:0] idx, logic [7:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == mrrs_pkg::CFG_DEV_ADDR) cur_addr = val;
  endtask

  // mostly well-formed requests with random content, plus noise frames
  task automatic random_frame();
    logic [7:0] body [$];
    int sel, len;
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      send_request($urandom_range(0, 9) == 0 ? 8'($urandom) : cur_addr, mrrs_pkg::FN_READ,
                   16'($urandom_range(0, 70)), 16'($urandom_range(0, 17)));
    end else if (sel < 70) begin
      send_request(cur_addr, mrrs_pkg::FN_WRITE, 16'($urandom_range(0, 70)),
                   16'($urandom));
    end else if (sel < 78) begin
      send_request(cur_addr, 8'($urandom), 16'($urandom), 16'($urandom));
    end else if (sel < 86) begin
      body = '{cur_addr, mrrs_pkg::FN_READ, 8'h00, 8'($urandom_range(0, 63)), 8'h00, 8'd2};
      send_frame(body, 1'b1);
    end else if (sel < 93) begin
      // extra payload bytes before the crc still form a valid frame
      body = '{cur_addr, mrrs_pkg::FN_READ, 8'h00, 8'($urandom_range(0, 63)), 8'h00, 8'd1};
      repeat ($urandom_range(1, 4)) body.push_back(8'($urandom));
      send_frame(body, 1'b0);
    end else begin
      len = $urandom_range(1, 9);
      for (int i = 0; i < len; i++) send_byte(8'($urandom), i == len - 1);
    end
  endtask

  initial begin
    logic [7:0] body [$];
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset register contents, extremes of count and index
    send_request(8'd1, mrrs_pkg::FN_READ, 16'd0, 16'd1);
    send_request(8'd1, mrrs_pkg::FN_READ, 16'd48, 16'd16);      // full max read
    send_request(8'd1, mrrs_pkg::FN_READ, 16'd60, 16'd8);       // reads past the end give 0
    send_request(8'd1, mrrs_pkg::FN_READ, 16'hFFFF, 16'd1);
    send_request(8'd1, mrrs_pkg::FN_READ, 16'd0, 16'd0);        // zero count dropped
    send_request(8'd1, mrrs_pkg::FN_READ, 16'd0, 16'd17);       // count too large dropped
    send_request(8'd1, mrrs_pkg::FN_WRITE, 16'd63, 16'hFFFF);
    send_request(8'd1, mrrs_pkg::FN_WRITE, 16'd64, 16'h1234);   // write out of range ignored
    send_request(8'd1, mrrs_pkg::FN_WRITE, 16'd0, 16'h0000);
    send_request(8'd1, mrrs_pkg::FN_READ, 16'd62, 16'd2);
    send_request(8'd2, mrrs_pkg::FN_READ, 16'd0, 16'd1);        // other address
    send_request(8'd1, 8'd4, 16'd0, 16'd1);                     // other function code
    body = '{8'd1, mrrs_pkg::FN_READ, 8'h00, 8'h00, 8'h00, 8'h01};
    send_frame(body, 1'b1);                                     // bad crc
    for (int i = 0; i < 5; i++) send_byte(8'hA5, i == 4);       // short frame
    send_byte(8'hFF, 1'b1);                                     // single-byte frame
    body = '{};
    for (int i = 0; i < 254; i++) body.push_back(i == 0 ? 8'd1 : 8'($urandom));
    body[1] = mrrs_pkg::FN_READ;
    body[4] = 8'h00;
    body[5] = 8'h03;
    send_frame(body, 1'b0);                                     // long frame, length saturates

    // config sweep with a burst of traffic at each setting
    write_cfg(mrrs_pkg::CFG_REG_USE, 8'd0);
    send_request(cur_addr, mrrs_pkg::FN_READ, 16'd0, 16'd2);
    write_cfg(mrrs_pkg::CFG_REG_USE, 8'd127);                   // clamped to the register count
    write_cfg(mrrs_pkg::CFG_DEV_ADDR, 8'd0);
    // long receiver hold-off while requests keep coming
    hold_off = 400;
    for (int i = 0; i < 3; i++)
      send_request(cur_addr, mrrs_pkg::FN_READ, 16'(i * 4), 16'd16);
    drain();                                                    // sender pause until all arrived
    write_cfg(mrrs_pkg::CFG_DEV_ADDR, 8'd255);
    write_cfg(mrrs_pkg::CFG_REG_USE, 8'd10);
    for (int i = 0; i < 3; i++) random_frame();
    write_cfg(mrrs_pkg::CFG_DEV_ADDR, 8'($urandom));
    write_cfg(mrrs_pkg::CFG_REG_USE, 8'($urandom_range(0, 127)));
    for (int i = 0; i < 2; i++) random_frame();
    write_cfg(mrrs_pkg::CFG_DEV_ADDR, 8'd1);
    write_cfg(mrrs_pkg::CFG_REG_USE, 8'd64);
    for (int i = 0; i < 2; i++) random_frame();
    quiet_mode = 1'b1;
    for (int i = 0; i < 2; i++) random_frame();

    while (pending_bytes != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fail_count == 0 && pending_bytes == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

>>> sim.f
design/mrrs_pkg.sv
design/mrrs_crc.sv
design/mrrs_regfile.sv
design/mrrs_ctrl.sv
design/modbus_rtu_register_slave_top.sv
design/mrrs_checker.sv
bench/modbus_slave_checker.sv
bench/tb_modbus_rtu_register_slave_top.sv
